FILE: hdl/qmpd_pkg.sv
package qmpd_pkg;

   // Field widths of the two channels and the configuration register.
   localparam int DataBits = 8;
   localparam int KindBits = 3;
   localparam int ValueBits = 32;
   localparam int SideBits = 2;
   localparam int StatusBits = 3;
   localparam int VertexBits = 20;

   // Running byte offset within a tile.
   localparam int CounterBits = 32;

   // Tile layout and limits.
   localparam int HeaderBytes = 92;
   localparam int CountFieldAt = 88;
   localparam int WideThreshold = 65536;
   localparam logic [VertexBits-1:0] MaxVerticesReset = VertexBits'(500000);

   // Result queue sizing.
   localparam int FifoDepth = 8;
   localparam int FifoAddrBits = $clog2(FifoDepth);
   localparam int FifoCountBits = $clog2(FifoDepth + 1);

   // Result kinds.
   typedef enum logic [KindBits-1:0] {
      KIND_U          = 3'd0,
      KIND_V          = 3'd1,
      KIND_HEIGHT     = 3'd2,
      KIND_TRI_COUNT  = 3'd3,
      KIND_TRI_INDEX  = 3'd4,
      KIND_EDGE_INDEX = 3'd5,
      KIND_END        = 3'd6
   } kind_type;

   // End-of-tile status codes.
   typedef enum logic [StatusBits-1:0] {
      STATUS_OK         = 3'd0,
      STATUS_TRUNCATED  = 3'd1,
      STATUS_BAD_COUNT  = 3'd2,
      STATUS_TRI_RANGE  = 3'd3,
      STATUS_EDGE_RANGE = 3'd4
   } status_type;

   // Edge list codes.
   localparam logic [SideBits-1:0] EdgeNorth = 2'd3;

   // One result item as held in the output queue.
   typedef struct packed {
      kind_type               kind;
      logic [ValueBits-1:0]   value;
      logic [SideBits-1:0]    edge_side;
      status_type             status;
      logic                   last;
   } result_type;

endpackage

FILE: hdl/quantized_mesh_payload_decoder.sv
// Streaming quantized-mesh tile decoder. Payload bytes arrive one per transfer on the req_
// channel; each byte is registered and decoded in the following cycle, and its results are
// written into the result queue that drives the rsp_ channel. While req_stall is low the
// block takes one byte every cycle: the decode of a byte is a single pass of small logic
// against the tile state, and results go into an 8-entry queue that drains one result per
// cycle while rsp_stall is low. A byte yields at most one decoded result (u, v, height,
// triangle count, triangle index or edge index); the byte flagged end_of_tile adds an end
// status result with rsp_last set, after which the tile state returns to its reset values.
// req_stall rises only when the queue cannot hold the worst case of two results for every
// byte in flight, so a steady byte rate needs the consumer to take roughly one result per
// cycle. A non-zero end status means every result of that tile must be discarded.
// max_vertices is written over the csr_ channel, which is always ready, and must only be
// changed while no tile is in flight.
module quantized_mesh_payload_decoder (
   input  logic                                   clock,
   input  logic                                   reset,
   // Byte input channel.
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [qmpd_pkg::DataBits-1:0]          req_data_byte,
   input  logic                                   req_end_of_tile,
   // Result channel.
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [qmpd_pkg::KindBits-1:0]          rsp_kind,
   output logic [qmpd_pkg::ValueBits-1:0]         rsp_value,
   output logic [qmpd_pkg::SideBits-1:0]          rsp_edge_side,
   output logic [qmpd_pkg::StatusBits-1:0]        rsp_status,
   output logic                                   rsp_last,
   // Configuration write channel.
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [qmpd_pkg::VertexBits-1:0]        csr_max_vertices
);
   import qmpd_pkg::*;

   typedef enum logic [3:0] {
      PH_HEADER    = 4'd0,
      PH_U         = 4'd1,
      PH_V         = 4'd2,
      PH_H         = 4'd3,
      PH_PAD       = 4'd4,
      PH_TRICOUNT  = 4'd5,
      PH_TRI       = 4'd6,
      PH_EDGECOUNT = 4'd7,
      PH_EDGE      = 4'd8,
      PH_TRAIL     = 4'd9,
      PH_SKIP      = 4'd10
   } phase_type;

   localparam int LeftBits = ValueBits + 2;

   // Configuration register.
   logic [VertexBits-1:0]   max_vertices_ff;

   // Input register.
   logic                    in_valid_ff;
   logic [DataBits-1:0]     in_byte_ff;
   logic                    in_eot_ff;

   // Tile state.
   phase_type               phase_ff, phase_in;
   logic [CounterBits-1:0]  pos_ff, pos_in;
   logic [ValueBits-1:0]    word_ff, word_in;
   logic [1:0]              biw_ff, biw_in;
   logic [VertexBits-1:0]   vertex_total_ff, vertex_total_in;
   logic [LeftBits-1:0]     left_ff, left_in;
   logic [15:0]             delta_ff, delta_in;
   logic [ValueBits-1:0]    high_water_ff, high_water_in;
   logic                    wide_ff, wide_in;
   logic [SideBits-1:0]     edge_ff, edge_in;
   status_type              first_error_ff, first_error_in;

   // Result queue.
   result_type              fifo_mem [FifoDepth];
   logic [FifoAddrBits-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FifoCountBits-1:0] count_ff;

   // Decode datapath.
   logic [DataBits-1:0]     take_data;
   logic [ValueBits-1:0]    word_or;
   logic [ValueBits-1:0]    word_hdr;
   logic                    need4;
   logic                    take_done;
   logic [LeftBits-1:0]     left_dec;
   logic [15:0]             zz;
   logic [15:0]             delta_val;
   logic [15:0]             delta_sum;
   logic [ValueBits-1:0]    tri_idx;
   logic [LeftBits-1:0]     tri_total;
   logic                    bad_count;
   logic                    pad_needed;
   result_type              res0, res1;
   logic                    res0_valid, res1_valid;

   // Queue control.
   logic                    push_ok;
   logic                    pop;
   logic [1:0]              push_count;
   logic [FifoAddrBits-1:0] wr_slot1;
   logic [FifoCountBits:0]  reserved;
   result_type              head;

   // Byte assembly of little-endian words; padding bytes count as zero.
   always_comb begin
      take_data = (phase_ff == PH_PAD) ? '0 : in_byte_ff;
      word_or   = word_ff | (ValueBits'(take_data) << {biw_ff, 3'b000});
      word_hdr  = word_ff | (ValueBits'(in_byte_ff) << {pos_ff[1:0], 3'b000});
      unique case (phase_ff)
         PH_TRICOUNT, PH_EDGECOUNT: need4 = 1'b1;
         PH_TRI, PH_EDGE:           need4 = wide_ff;
         default:                   need4 = 1'b0;
      endcase
      take_done = need4 ? (biw_ff == 2'd3) : (biw_ff != 2'd0);
   end

   // Per-phase arithmetic.
   always_comb begin
      left_dec   = left_ff - LeftBits'(1);
      zz         = word_or[15:0];
      delta_val  = {1'b0, zz[15:1]} ^ {16{zz[0]}};
      delta_sum  = delta_ff + delta_val;
      tri_idx    = high_water_ff - word_or;
      tri_total  = {2'b00, word_or} + {1'b0, word_or, 1'b0};
      bad_count  = (word_hdr == '0) || (word_hdr > ValueBits'(max_vertices_ff));
      pad_needed = (pos_ff[1:0] + 2'd1) != 2'd0;
   end

   // Next tile state and the results caused by the registered byte.
   always_comb begin
      phase_in        = phase_ff;
      pos_in          = pos_ff;
      word_in         = word_ff;
      biw_in          = biw_ff;
      vertex_total_in = vertex_total_ff;
      left_in         = left_ff;
      delta_in        = delta_ff;
      high_water_in   = high_water_ff;
      wide_in         = wide_ff;
      edge_in         = edge_ff;
      first_error_in  = first_error_ff;
      res0            = '0;
      res1            = '0;
      res0_valid      = 1'b0;
      res1_valid      = 1'b0;

      if (in_valid_ff) begin
         pos_in = pos_ff + CounterBits'(1);

         // Word collection shared by the u, v, height, padding, count, triangle and edge phases.
         if (phase_ff != PH_HEADER && phase_ff != PH_TRAIL && phase_ff != PH_SKIP) begin
            word_in = take_done ? '0 : word_or;
            biw_in  = take_done ? 2'd0 : biw_ff + 2'd1;
         end

         unique case (phase_ff)
            PH_HEADER: begin
               if (pos_ff >= CounterBits'(CountFieldAt) &&
                   pos_ff < CounterBits'(HeaderBytes)) begin
                  word_in = word_hdr;
               end
               if (pos_ff >= CounterBits'(HeaderBytes - 1)) begin
                  word_in = '0;
                  if (bad_count) begin
                     first_error_in = STATUS_BAD_COUNT;
                     phase_in       = PH_SKIP;
                  end else begin
                     vertex_total_in = word_hdr[VertexBits-1:0];
                     wide_in         = word_hdr > ValueBits'(WideThreshold);
                     left_in         = {2'b00, word_hdr};
                     delta_in        = '0;
                     phase_in        = PH_U;
                  end
               end
            end
            PH_U, PH_V, PH_H: begin
               if (take_done) begin
                  res0_valid  = 1'b1;
                  res0.value  = ValueBits'(delta_sum);
                  unique case (phase_ff)
                     PH_U:    res0.kind = KIND_U;
                     PH_V:    res0.kind = KIND_V;
                     default: res0.kind = KIND_HEIGHT;
                  endcase
                  delta_in = delta_sum;
                  left_in  = left_dec;
                  if (left_dec == '0) begin
                     delta_in = '0;
                     if (phase_ff == PH_U) begin
                        phase_in = PH_V;
                        left_in  = LeftBits'(vertex_total_ff);
                     end else if (phase_ff == PH_V) begin
                        phase_in = PH_H;
                        left_in  = LeftBits'(vertex_total_ff);
                     end else if (wide_ff && pad_needed) begin
                        phase_in = PH_PAD;
                     end else begin
                        phase_in = PH_TRICOUNT;
                     end
                  end
               end
            end
            PH_PAD: begin
               if (take_done) begin
                  phase_in = PH_TRICOUNT;
               end
            end
            PH_TRICOUNT: begin
               if (take_done) begin
                  res0_valid    = 1'b1;
                  res0.kind     = KIND_TRI_COUNT;
                  res0.value    = word_or;
                  left_in       = tri_total;
                  high_water_in = '0;
                  edge_in       = '0;
                  phase_in      = (word_or != '0) ? PH_TRI : PH_EDGECOUNT;
               end
            end
            PH_TRI: begin
               if (take_done) begin
                  if (word_or == '0) begin
                     high_water_in = high_water_ff + ValueBits'(1);
                  end
                  if (tri_idx >= ValueBits'(vertex_total_ff) &&
                      first_error_ff == STATUS_OK) begin
                     first_error_in = STATUS_TRI_RANGE;
                  end
                  res0_valid = 1'b1;
                  res0.kind  = KIND_TRI_INDEX;
                  res0.value = tri_idx;
                  left_in    = left_dec;
                  if (left_dec == '0) begin
                     phase_in = PH_EDGECOUNT;
                  end
               end
            end
            PH_EDGECOUNT: begin
               if (take_done) begin
                  left_in = {2'b00, word_or};
                  if (word_or != '0) begin
                     phase_in = PH_EDGE;
                  end else if (edge_ff == EdgeNorth) begin
                     phase_in = PH_TRAIL;
                  end else begin
                     edge_in  = edge_ff + SideBits'(1);
                     phase_in = PH_EDGECOUNT;
                  end
               end
            end
            PH_EDGE: begin
               if (take_done) begin
                  if (word_or >= ValueBits'(vertex_total_ff) &&
                      first_error_ff == STATUS_OK) begin
                     first_error_in = STATUS_EDGE_RANGE;
                  end
                  res0_valid     = 1'b1;
                  res0.kind      = KIND_EDGE_INDEX;
                  res0.value     = word_or;
                  res0.edge_side = edge_ff;
                  left_in        = left_dec;
                  if (left_dec == '0) begin
                     if (edge_ff == EdgeNorth) begin
                        phase_in = PH_TRAIL;
                     end else begin
                        edge_in  = edge_ff + SideBits'(1);
                        phase_in = PH_EDGECOUNT;
                     end
                  end
               end
            end
            default: begin
               // Trailing extension bytes and rejected tiles are ignored.
            end
         endcase

         // End of tile: report the status and return to the start of a tile.
         if (in_eot_ff) begin
            res1_valid = 1'b1;
            res1.kind  = KIND_END;
            res1.last  = 1'b1;
            priority if (phase_in == PH_TRAIL || phase_in == PH_SKIP) begin
               res1.status = first_error_in;
            end else if ((phase_in == PH_EDGECOUNT || phase_in == PH_EDGE) &&
                         first_error_in == STATUS_TRI_RANGE) begin
               res1.status = STATUS_TRI_RANGE;
            end else begin
               res1.status = STATUS_TRUNCATED;
            end
            phase_in        = PH_HEADER;
            pos_in          = '0;
            word_in         = '0;
            biw_in          = '0;
            vertex_total_in = '0;
            left_in         = '0;
            delta_in        = '0;
            high_water_in   = '0;
            wide_in         = 1'b0;
            edge_in         = '0;
            first_error_in  = STATUS_OK;
         end
      end
   end

   // Queue bookkeeping: room is reserved for two results per byte in flight.
   always_comb begin
      reserved   = (FifoCountBits + 1)'(count_ff) + (FifoCountBits + 1)'({in_valid_ff, 1'b0});
      push_ok    = reserved <= (FifoCountBits + 1)'(FifoDepth - 2);
      pop        = rsp_valid && !rsp_stall;
      push_count = 2'(res0_valid) + 2'(res1_valid);
      wr_slot1   = wr_ptr_ff + FifoAddrBits'(res0_valid);
      head       = fifo_mem[rd_ptr_ff];
   end

   assign req_stall     = !push_ok;
   assign csr_ready     = 1'b1;
   assign rsp_valid     = count_ff != '0;
   assign rsp_kind      = head.kind;
   assign rsp_value     = head.value;
   assign rsp_edge_side = head.edge_side;
   assign rsp_status    = head.status;
   assign rsp_last      = head.last;

   // Result queue storage.
   always_ff @(posedge clock) begin
      if (res0_valid) begin
         fifo_mem[wr_ptr_ff] <= res0;
      end
      if (res1_valid) begin
         fifo_mem[wr_slot1] <= res1;
      end
   end

   // Input register, configuration, tile state and queue pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_vertices_ff <= MaxVerticesReset;
         in_valid_ff     <= 1'b0;
         phase_ff        <= PH_HEADER;
         pos_ff          <= '0;
         word_ff         <= '0;
         biw_ff          <= '0;
         vertex_total_ff <= '0;
         left_ff         <= '0;
         delta_ff        <= '0;
         high_water_ff   <= '0;
         wide_ff         <= 1'b0;
         edge_ff         <= '0;
         first_error_ff  <= STATUS_OK;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_vertices_ff <= csr_max_vertices;
         end
         in_valid_ff     <= req_valid && !req_stall;
         phase_ff        <= phase_in;
         pos_ff          <= pos_in;
         word_ff         <= word_in;
         biw_ff          <= biw_in;
         vertex_total_ff <= vertex_total_in;
         left_ff         <= left_in;
         delta_ff        <= delta_in;
         high_water_ff   <= high_water_in;
         wide_ff         <= wide_in;
         edge_ff         <= edge_in;
         first_error_ff  <= first_error_in;
         wr_ptr_ff       <= wr_ptr_ff + FifoAddrBits'(push_count);
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FifoAddrBits'(1);
         end
         count_ff <= count_ff + FifoCountBits'(push_count) - FifoCountBits'(pop);
      end
   end

   // Payload capture of each accepted byte.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_eot_ff  <= req_end_of_tile;
      end
   end

endmodule
